FILE: hdl/cfq_pkg.sv
// Shared opcodes, status codes and register map for the circular queue FIFO.
package cfq_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_ENQ  = 2'd0;
  localparam opcode_t OP_DEQ  = 2'd1;
  localparam opcode_t OP_PEEK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  localparam logic REG_CAPACITY = 1'b0;

  localparam int                    CAPACITY_W     = 5;
  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

FILE: hdl/cfq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/circular_queue_fifo.sv
// Top level of the circular queue FIFO with status, count and flags per request.
// An accepted request is registered in stage s1, then in the output registers.
// Throughput: one request per cycle unless in_stall; one RAM read port limits it.
// Pointers and count update at acceptance, so a read always sees earlier writes.
// Reset is synchronous and active low: the queue is empty, pointers are zero and
// the capacity returns to 16; stored data is not cleared.
module circular_queue_fifo #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  cfq_pkg::opcode_t                     in_opcode,
  input  logic signed [DATA_WIDTH-1:0]         in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [DATA_WIDTH-1:0]         out_read_data,
  output cfq_pkg::status_t                     out_status,
  output logic [$clog2(DEPTH+1)-1:0]           out_entry_count,
  output logic                                 out_empty_flag,
  output logic                                 out_is_full,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import cfq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CAPACITY_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          s1_valid_r, s1_valid_nxt;
  status_t       s1_status_r, s1_status_nxt;
  logic          s1_rd_ok_r, s1_rd_ok_nxt;
  logic [CW-1:0] s1_count_r;
  logic          s1_empty_r, s1_empty_nxt;
  logic          s1_full_r, s1_full_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r;
  status_t               out_status_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_empty_r;
  logic                  out_full_r;

  logic [CW-1:0]         eff_cap;
  logic                  in_fire;
  logic                  s1_move;
  logic                  cfg_we;
  logic                  q_full;
  logic                  q_empty;
  logic                  do_wr;
  logic                  do_rd;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx, input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(idx) + CW'(1);
    return (n >= cap) ? '0 : n[AW-1:0];
  endfunction

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_r) > DEPTH) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  assign q_full  = count_r >= eff_cap;
  assign q_empty = count_r == '0;
  assign do_wr   = in_fire && (in_opcode == OP_ENQ) && !q_full;
  assign do_rd   = in_fire && ((in_opcode == OP_DEQ) || (in_opcode == OP_PEEK)) && !q_empty;

  always_comb begin
    cap_nxt       = cap_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    s1_status_nxt = ST_OK;
    s1_rd_ok_nxt  = 1'b0;
    if (in_fire) begin
      case (in_opcode)
        OP_ENQ: begin
          if (q_full) begin
            s1_status_nxt = ST_OVER;
          end else begin
            tail_nxt  = advance(tail_r, eff_cap);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DEQ: begin
          if (q_empty) begin
            s1_status_nxt = ST_UNDER;
          end else begin
            s1_rd_ok_nxt = 1'b1;
            head_nxt     = advance(head_r, eff_cap);
            count_nxt    = count_r - CW'(1);
          end
        end
        OP_PEEK: begin
          if (q_empty) begin
            s1_status_nxt = ST_UNDER;
          end else begin
            s1_rd_ok_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_we && q_empty) begin
      cap_nxt  = pwdata[CAPACITY_W-1:0];
      head_nxt = '0;
      tail_nxt = '0;
    end
    s1_empty_nxt = count_nxt == '0;
    s1_full_nxt  = count_nxt == eff_cap;
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAPACITY_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= s1_status_nxt;
      s1_rd_ok_r  <= s1_rd_ok_nxt;
      s1_count_r  <= count_nxt;
      s1_empty_r  <= s1_empty_nxt;
      s1_full_r   <= s1_full_nxt;
    end
    if (s1_move) begin
      out_data_r   <= s1_rd_ok_r ? ram_rd_data : '0;
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
      out_empty_r  <= s1_empty_r;
      out_full_r   <= s1_full_r;
    end
  end

  cfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_wr),
    .wr_addr (tail_r),
    .wr_data (in_value),
    .rd_en   (do_rd),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_empty_flag  = out_empty_r;
  assign out_is_full     = out_full_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_r) : '0;

endmodule
